// File: src/u8u16_pkg.sv
package u8u16_pkg;

    localparam longint unsigned MAX_STRING_BYTES = 64'd1048576;
    localparam int CNT_W = 21;
    localparam longint unsigned CAP21 = 64'h1F_FFFF;
    localparam logic [CNT_W-1:0] SAT_LIMIT =
        CNT_W'((MAX_STRING_BYTES < CAP21) ? MAX_STRING_BYTES : CAP21);

    localparam logic [7:0] LEAD_MIN   = 8'hC2;
    localparam logic [7:0] LEAD_MAX   = 8'hF4;
    localparam logic [7:0] LEAD_3B    = 8'hE0;
    localparam logic [7:0] LEAD_4B    = 8'hF0;
    localparam logic [7:0] ASCII_LIM  = 8'h80;

    localparam logic [13:0] C4_LOW    = 14'h3C90;
    localparam logic [13:0] C4_HIGH   = 14'h3D8F;
    localparam logic [13:0] C3_LOW    = 14'h38A0;
    localparam logic [13:0] SURR_LOW  = 14'h3BE0;
    localparam logic [13:0] SURR_HIGH = 14'h3BFF;

    localparam logic [20:0] SUPP_BASE = 21'h10000;
    localparam logic [15:0] HI_SURR   = 16'hD800;
    localparam logic [15:0] LO_SURR   = 16'hDC00;

    typedef struct packed {
        logic [15:0]      unit;
        logic             is_error;
        logic             done;
        logic             run_last;
        logic [CNT_W-1:0] total;
        logic [CNT_W-1:0] offset;
    } t_result;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v >= SAT_LIMIT) ? SAT_LIMIT : v + CNT_W'(1);
    endfunction

endpackage

// File: src/utf8_to_utf16_stream_decoder.sv
// channel   dir  signals                              contents
// s_axis    in   tvalid/tready/tdata[7:0]/tlast       tdata: byte_in; tlast: end_of_input
// m_axis    out  tvalid/tready/tdata[63:0]/tlast/tuser tlast: string_done; tuser: is_error,
//                                                     run_last; tdata: unit, total, offset
// cfg       in   valid/ready/data[0]                  stop_at_nul, always ready
//
// one byte per cycle sustained while the output is not stalled: input register, one pass of decode logic, result queue
// a byte's first result passes through the input register and then the result queue before it reaches the output
// a surrogate pair leaves as two words in turn from a three-slot result queue
// synchronous active-low reset clears decode state and sets stop_at_nul
// an output stall holds the queue; a byte is decoded only while the queue has room for two
module utf8_to_utf16_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] byte_in
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [15:0] unit_out, [36:16] units_total,
                                          // [57:37] error_offset, [63:58] zero
    output logic        o_m_axis_tlast,
    output logic [1:0]  o_m_axis_tuser,   // [0] is_error, [1] run_last
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_data
);

    localparam int W = u8u16_pkg::CNT_W;

    logic        r_stop;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    logic [1:0]  r_pending,  n_pending;
    logic [7:0]  r_lead,     n_lead;
    logic [20:0] r_accum,    n_accum;
    logic        r_first,    n_first;
    logic [W-1:0] r_seq,     n_seq;
    logic [W-1:0] r_pos,     n_pos;
    logic [W-1:0] r_ucnt,    n_ucnt;
    logic        r_discard,  n_discard;

    u8u16_pkg::t_result r_q [3];
    u8u16_pkg::t_result n_q [3];
    logic [1:0]  r_qcnt, n_qcnt;

    u8u16_pkg::t_result res0, res1;
    logic [1:0]  nres;
    logic        bad, ends, fire, pop, accept;
    logic [1:0]  qcnt_after;
    logic [13:0] c;
    logic [20:0] acc_new;
    logic [19:0] v;
    logic [W-1:0] cnt1, cnt2;

    assign o_cfg_ready     = 1'b1;
    assign pop             = o_m_axis_tvalid && i_m_axis_tready;
    assign qcnt_after      = r_qcnt - {1'b0, pop};
    assign fire            = r_in_valid && (qcnt_after <= 2'd1);
    assign o_s_axis_tready = !r_in_valid || fire;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid = (r_qcnt != 2'd0);
    assign o_m_axis_tdata  = {6'd0, r_q[0].offset, r_q[0].total, r_q[0].unit};
    assign o_m_axis_tlast  = r_q[0].done;
    assign o_m_axis_tuser  = {r_q[0].run_last, r_q[0].is_error};

    // decode
    always_comb begin
        n_pending = r_pending;
        n_lead    = r_lead;
        n_accum   = r_accum;
        n_first   = r_first;
        n_seq     = r_seq;
        n_discard = r_discard;
        n_ucnt    = r_ucnt;
        bad       = 1'b0;
        nres      = 2'd0;
        c         = {r_lead, 6'd0} + {6'd0, r_in_byte};
        acc_new   = {r_accum[14:0], r_in_byte[5:0]};
        v         = 20'(acc_new - u8u16_pkg::SUPP_BASE);
        cnt1      = u8u16_pkg::sat_inc(r_ucnt);
        cnt2      = u8u16_pkg::sat_inc(cnt1);
        ends      = r_in_last || (r_stop && r_in_byte == 8'd0);
        n_pos     = u8u16_pkg::sat_inc(r_pos);

        res0          = '0;
        res1          = '0;
        res0.total    = cnt1;
        res1.total    = cnt2;
        res1.run_last = 1'b1;

        if (r_discard) begin
            if (ends) begin
                n_discard = 1'b0;
                n_pending = 2'd0;
                n_lead    = 8'd0;
                n_accum   = 21'd0;
                n_first   = 1'b0;
                n_seq     = '0;
                n_pos     = '0;
                n_ucnt    = '0;
            end
        end else begin
            if (r_pending == 2'd0) begin
                n_seq = r_pos;
                if (r_in_byte < u8u16_pkg::ASCII_LIM) begin
                    nres      = 2'd1;
                    res0.unit = {8'd0, r_in_byte};
                end else if (r_in_byte < u8u16_pkg::LEAD_MIN
                             || r_in_byte > u8u16_pkg::LEAD_MAX) begin
                    bad = 1'b1;
                end else begin
                    n_lead = r_in_byte;
                    if (r_in_byte < u8u16_pkg::LEAD_3B) begin
                        n_pending = 2'd1;
                        n_accum   = {16'd0, r_in_byte[4:0]};
                        n_first   = 1'b0;
                    end else if (r_in_byte < u8u16_pkg::LEAD_4B) begin
                        n_pending = 2'd2;
                        n_accum   = {17'd0, r_in_byte[3:0]};
                        n_first   = 1'b1;
                    end else begin
                        n_pending = 2'd3;
                        n_accum   = {18'd0, r_in_byte[2:0]};
                        n_first   = 1'b1;
                    end
                end
            end else begin
                if (r_in_byte[7:6] != 2'b10) begin
                    bad = 1'b1;
                end else if (r_first) begin
                    if (r_lead >= u8u16_pkg::LEAD_4B) begin
                        bad = !(c >= u8u16_pkg::C4_LOW && c <= u8u16_pkg::C4_HIGH);
                    end else begin
                        bad = !((c >= u8u16_pkg::C3_LOW)
                                && !(c >= u8u16_pkg::SURR_LOW && c <= u8u16_pkg::SURR_HIGH));
                    end
                end
                if (!bad) begin
                    n_accum   = acc_new;
                    n_first   = 1'b0;
                    n_pending = r_pending - 2'd1;
                    if (r_pending == 2'd1) begin
                        if (acc_new >= u8u16_pkg::SUPP_BASE) begin
                            nres      = 2'd2;
                            res0.unit = u8u16_pkg::HI_SURR + {6'd0, v[19:10]};
                            res1.unit = u8u16_pkg::LO_SURR + {6'd0, v[9:0]};
                        end else begin
                            nres      = 2'd1;
                            res0.unit = acc_new[15:0];
                        end
                    end
                end
            end

            if (!bad && ends && n_pending != 2'd0) begin
                bad = 1'b1;
            end

            if (nres == 2'd1) begin
                n_ucnt        = cnt1;
                res0.run_last = 1'b1;
            end else if (nres == 2'd2) begin
                n_ucnt = cnt2;
            end

            if (bad) begin
                nres          = 2'd1;
                res0          = '0;
                res0.is_error = 1'b1;
                res0.done     = 1'b1;
                res0.run_last = 1'b1;
                res0.total    = r_ucnt;
                res0.offset   = n_seq;
                n_discard     = !ends;
                n_pending     = 2'd0;
                n_first       = 1'b0;
            end else if (ends && nres != 2'd0) begin
                res0.done = (nres == 2'd1);
                res1.done = 1'b1;
            end

            if (ends && (bad || nres != 2'd0)) begin
                n_discard = 1'b0;
                n_pending = 2'd0;
                n_lead    = 8'd0;
                n_accum   = 21'd0;
                n_first   = 1'b0;
                n_seq     = '0;
                n_pos     = '0;
                n_ucnt    = '0;
            end
        end
    end

    // result queue, head in slot 0
    always_comb begin
        n_q[0] = pop ? r_q[1] : r_q[0];
        n_q[1] = pop ? r_q[2] : r_q[1];
        n_q[2] = r_q[2];
        n_qcnt = qcnt_after;
        if (fire) begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) == qcnt_after && nres != 2'd0) begin
                    n_q[i] = res0;
                end
                if (2'(i) == qcnt_after + 2'd1 && nres == 2'd2) begin
                    n_q[i] = res1;
                end
            end
            n_qcnt = qcnt_after + nres;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop     <= 1'b1;
            r_in_valid <= 1'b0;
            r_qcnt     <= 2'd0;
            r_pending  <= 2'd0;
            r_lead     <= 8'd0;
            r_accum    <= 21'd0;
            r_first    <= 1'b0;
            r_seq      <= '0;
            r_pos      <= '0;
            r_ucnt     <= '0;
            r_discard  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_stop <= i_cfg_data[0];
            end
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            r_qcnt <= n_qcnt;
            if (fire) begin
                r_pending <= n_pending;
                r_lead    <= n_lead;
                r_accum   <= n_accum;
                r_first   <= n_first;
                r_seq     <= n_seq;
                r_pos     <= n_pos;
                r_ucnt    <= n_ucnt;
                r_discard <= n_discard;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
        r_q <= n_q;
    end

endmodule

// File: test/utf8_to_utf16_stream_decoder_test.sv
`timescale 1ns / 100ps

module utf8_to_utf16_stream_decoder_test;

    typedef logic [7:0] octet_q[$];

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 8'h00;   // [7:0] byte_in
    logic        i_s_axis_tlast = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [63:0] o_m_axis_tdata;           // [15:0] unit, [36:16] total, [57:37] offset
    logic        o_m_axis_tlast;
    logic [1:0]  o_m_axis_tuser;           // [0] is_error, [1] run_last
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_data = 1'b0;

    // decoder state as predicted
    logic        nul_ends = 1'b1;
    logic [1:0]  dec_pending = '0;
    logic [7:0]  dec_lead = '0;
    logic [20:0] dec_accum = '0;
    logic        dec_first = 1'b0;
    logic [20:0] dec_start = '0;
    logic [20:0] dec_pos = '0;
    logic [20:0] dec_units = '0;
    logic        dec_dropping = 1'b0;

    u8u16_pkg::t_result units_due[$];
    u8u16_pkg::t_result head;
    int          mismatches = 0;
    int          bytes_sent = 0;
    int          hold_left = 0;
    logic        src_gaps = 1'b1;
    logic        sink_stalls = 1'b1;
    octet_q      str_bytes;

    utf8_to_utf16_stream_decoder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #80_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int draw_wait(input logic en);
        if (!en || $urandom_range(0, 2) == 0) begin
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    function automatic logic [20:0] count_up(input logic [20:0] v);
        return (v >= u8u16_pkg::SAT_LIMIT) ? u8u16_pkg::SAT_LIMIT : v + 21'd1;
    endfunction

    function automatic void clear_string_state();
        dec_pending = '0;
        dec_lead = '0;
        dec_accum = '0;
        dec_first = 1'b0;
        dec_start = '0;
        dec_pos = '0;
        dec_units = '0;
        dec_dropping = 1'b0;
    endfunction

    function automatic u8u16_pkg::t_result unit_word(input logic [15:0] u);
        u8u16_pkg::t_result r;
        dec_units = count_up(dec_units);
        r = '0;
        r.unit = u;
        r.total = dec_units;
        return r;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic eoi);
        u8u16_pkg::t_result res[3];
        u8u16_pkg::t_result err;
        int          n;
        int          k;
        logic        ends;
        logic        bad;
        logic        ok;
        logic [20:0] pos;
        logic [13:0] pair;
        logic [19:0] v;
        n = 0;
        bad = 1'b0;
        ends = eoi || (nul_ends && b == 8'h00);
        pos = dec_pos;
        dec_pos = count_up(dec_pos);
        if (dec_dropping) begin
            if (ends) begin
                clear_string_state();
            end
            return;
        end
        if (dec_pending == 2'd0) begin
            dec_start = pos;
            if (b < 8'h80) begin
                res[n] = unit_word({8'h00, b});
                n++;
            end else if (b < 8'hC2 || b > 8'hF4) begin
                bad = 1'b1;
            end else begin
                dec_lead = b;
                if (b < 8'hE0) begin
                    dec_pending = 2'd1;
                    dec_accum = 21'(b[4:0]);
                    dec_first = 1'b0;
                end else if (b < 8'hF0) begin
                    dec_pending = 2'd2;
                    dec_accum = 21'(b[3:0]);
                    dec_first = 1'b1;
                end else begin
                    dec_pending = 2'd3;
                    dec_accum = 21'(b[2:0]);
                    dec_first = 1'b1;
                end
            end
        end else begin
            if (b[7:6] != 2'b10) begin
                bad = 1'b1;
            end else if (dec_first) begin
                // lead and first continuation together bound the code point range
                pair = {dec_lead, 6'b000000} + 14'(b);
                if (dec_lead >= 8'hF0) begin
                    ok = (pair >= 14'h3C90) && (pair <= 14'h3D8F);
                end else begin
                    ok = (pair >= 14'h38A0) && !((pair >= 14'h3BE0) && (pair <= 14'h3BFF));
                end
                if (!ok) begin
                    bad = 1'b1;
                end
            end
            if (!bad) begin
                dec_accum = {dec_accum[14:0], b[5:0]};
                dec_first = 1'b0;
                dec_pending = dec_pending - 2'd1;
                if (dec_pending == 2'd0) begin
                    if (dec_accum >= 21'h10000) begin
                        v = 20'(dec_accum - 21'h10000);
                        res[n] = unit_word(16'hD800 + 16'(v[19:10]));
                        n++;
                        res[n] = unit_word(16'hDC00 + 16'(v[9:0]));
                        n++;
                    end else begin
                        res[n] = unit_word(dec_accum[15:0]);
                        n++;
                    end
                end
            end
        end
        if (!bad && ends && dec_pending != 2'd0) begin
            bad = 1'b1;
        end
        if (bad) begin
            err = '0;
            err.is_error = 1'b1;
            err.done = 1'b1;
            err.total = dec_units;
            err.offset = dec_start;
            res[n] = err;
            n++;
            if (ends) begin
                clear_string_state();
            end else begin
                dec_dropping = 1'b1;
                dec_pending = 2'd0;
                dec_first = 1'b0;
            end
        end else if (ends && n > 0) begin
            res[n-1].done = 1'b1;
            clear_string_state();
        end
        if (n > 0) begin
            res[n-1].run_last = 1'b1;
        end
        for (k = 0; k < n; k++) begin
            units_due.push_back(res[k]);
        end
    endfunction

    function automatic void check_field(input string what, input logic [20:0] want,
                                        input logic [20:0] got);
        if (want !== got) begin
            $display("%0t %s mismatch: expected %0h actual %0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (units_due.size() == 0) begin
                $display("%0t unexpected word: expected none actual tdata %h tuser %b tlast %b",
                         $time, o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                mismatches++;
            end else begin
                head = units_due.pop_front();
                check_field("unit", 21'(head.unit), 21'(o_m_axis_tdata[15:0]));
                check_field("units_total", head.total, o_m_axis_tdata[36:16]);
                check_field("error_offset", head.offset, o_m_axis_tdata[57:37]);
                check_field("tdata pad", 21'd0, 21'(o_m_axis_tdata[63:58]));
                check_field("is_error", 21'(head.is_error), 21'(o_m_axis_tuser[0]));
                check_field("run_last", 21'(head.run_last), 21'(o_m_axis_tuser[1]));
                check_field("string_done", 21'(head.done), 21'(o_m_axis_tlast));
            end
        end
    end

    // sink side: after each word hold tready low for a drawn number of cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            hold_left = 0;
        end else if (i_m_axis_tready) begin
            if (o_m_axis_tvalid) begin
                hold_left = draw_wait(sink_stalls);
                if (hold_left != 0) begin
                    i_m_axis_tready <= 1'b0;
                end
            end
        end else if (hold_left > 1) begin
            hold_left--;
        end else begin
            hold_left = 0;
            i_m_axis_tready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eoi);
        int gap;
        gap = draw_wait(src_gaps);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= b;
        i_s_axis_tlast <= eoi;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        decode_byte(b, eoi);
        bytes_sent++;
    endtask

    task automatic send_string(input octet_q seq, input logic close);
        foreach (seq[i]) begin
            send_byte(seq[i], close && (i == seq.size() - 1));
        end
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (units_due.size() != 0);
        @(posedge i_clk);
    endtask

    task automatic write_nul_mode(input logic v);
        wait_drained();
        // a dropped or lead byte may still be in the pipeline
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        nul_ends = v;
    endtask

    function automatic void encode_cp(input int unsigned cp);
        if (cp < 32'h80) begin
            str_bytes.push_back(8'(cp));
        end else if (cp < 32'h800) begin
            str_bytes.push_back(8'hC0 | 8'(cp >> 6));
            str_bytes.push_back(8'h80 | 8'(cp & 32'h3F));
        end else if (cp < 32'h10000) begin
            str_bytes.push_back(8'hE0 | 8'(cp >> 12));
            str_bytes.push_back(8'h80 | 8'((cp >> 6) & 32'h3F));
            str_bytes.push_back(8'h80 | 8'(cp & 32'h3F));
        end else begin
            str_bytes.push_back(8'hF0 | 8'(cp >> 18));
            str_bytes.push_back(8'h80 | 8'((cp >> 12) & 32'h3F));
            str_bytes.push_back(8'h80 | 8'((cp >> 6) & 32'h3F));
            str_bytes.push_back(8'h80 | 8'(cp & 32'h3F));
        end
    endfunction

    function automatic int unsigned edge_cp();
        case ($urandom_range(0, 8))
            0: return 32'h7F;
            1: return 32'h80;
            2: return 32'h7FF;
            3: return 32'h800;
            4: return 32'hD7FF;
            5: return 32'hE000;
            6: return 32'hFFFF;
            7: return 32'h10000;
            default: return 32'h10FFFF;
        endcase
    endfunction

    task automatic send_random_string();
        int   n_chars;
        int   kind;
        int   mark;
        logic dirty;
        logic close;
        str_bytes.delete();
        n_chars = $urandom_range(1, 10);
        dirty = ($urandom_range(0, 3) == 0);
        repeat (n_chars) begin
            kind = $urandom_range(0, dirty ? 29 : 25);
            mark = str_bytes.size();
            if (kind < 8) begin
                encode_cp(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8'h7F));
            end else if (kind < 13) begin
                encode_cp($urandom_range(16'h80, 16'h7FF));
            end else if (kind < 20) begin
                encode_cp($urandom_range(16'h800, 16'hFFFF));
            end else if (kind < 25) begin
                encode_cp($urandom_range(32'h10000, 32'h10FFFF));
            end else if (kind == 25) begin
                encode_cp(edge_cp());
            end else if (kind == 26) begin
                // sequence missing its tail
                encode_cp($urandom_range(16'h800, 32'h10FFFF));
                void'(str_bytes.pop_back());
            end else if (kind == 27) begin
                // first continuation replaced by any byte
                encode_cp($urandom_range(16'h800, 32'h10FFFF));
                str_bytes[mark + 1] = 8'($urandom_range(0, 255));
            end else if (kind == 28) begin
                str_bytes.push_back(8'($urandom_range(8'h80, 8'hFF)));
            end else begin
                str_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        close = ($urandom_range(0, 9) != 0);
        send_string(str_bytes, close);
    endtask

    task automatic test_plain_bytes();
        send_string('{8'h00}, 1'b0);
        send_string('{8'h41, 8'h7F}, 1'b1);
    endtask

    task automatic test_multibyte();
        send_string('{8'hDF, 8'hBF, 8'hE0, 8'hA0, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF}, 1'b1);
    endtask

    task automatic test_malformed();
        send_string('{8'h80, 8'h41}, 1'b1);
        send_string('{8'hE0, 8'h9F}, 1'b1);
        send_string('{8'hF0, 8'h8F}, 1'b1);
        send_string('{8'hED, 8'hA0}, 1'b1);
        send_string('{8'hF4, 8'h90}, 1'b1);
        send_string('{8'h41, 8'hE2, 8'h82}, 1'b1);
        send_string('{8'hC2, 8'h00}, 1'b0);
        send_string('{8'h42, 8'hE1, 8'hC3, 8'h41}, 1'b1);
    endtask

    task automatic test_nul_mode();
        write_nul_mode(1'b0);
        send_string('{8'h00, 8'h41}, 1'b1);
        send_string('{8'hC2, 8'h00, 8'h41}, 1'b1);
        write_nul_mode(1'b1);
    endtask

    task automatic test_random();
        int phase;
        for (phase = 0; phase < 6; phase++) begin
            if (phase < 2) begin
                write_nul_mode(phase[0]);
            end else begin
                write_nul_mode(1'($urandom_range(0, 1)));
            end
            src_gaps = (phase != 2) && (phase != 4);
            sink_stalls = (phase != 2) && (phase != 3);
            while (bytes_sent < 40 + (phase + 1) * 110) begin
                send_random_string();
                if ($urandom_range(0, 24) == 0) begin
                    wait_drained();
                end
            end
        end
    endtask

    task automatic test_back_to_back();
        int k;
        src_gaps = 1'b0;
        sink_stalls = 1'b0;
        send_byte(8'h20, 1'b1);
        for (k = 0; k < 16; k++) begin
            send_byte(8'h41, 1'b0);
        end
        send_byte(8'h80, 1'b0);
        send_byte(8'h41, 1'b1);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_plain_bytes();
        test_multibyte();
        test_malformed();
        test_nul_mode();
        test_random();
        test_back_to_back();
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: sim.f
src/u8u16_pkg.sv
src/utf8_to_utf16_stream_decoder.sv
test/utf8_to_utf16_stream_decoder_test.sv
